// ----- sv/a64dp_pkg.sv -----
// Shared types, codes and helpers for the A64 data-processing execute block.
`default_nettype none
package a64dp_pkg;

    localparam int XLEN     = 64;
    localparam int NREGS    = 31;
    localparam int IMM_SH   = 12;
    localparam int QDEPTH   = 2;
    localparam logic [4:0] ZR = 5'd31;

    typedef enum logic [1:0] {
        REQ_EXEC = 2'd0,
        REQ_LOAD = 2'd1,
        REQ_READ = 2'd2,
        REQ_NONE = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_ADDI,
        OP_MOVW,
        OP_LOGIC,
        OP_ADDR,
        OP_MADD,
        OP_UNSUP
    } op_t;

    // classified item from the front part
    typedef struct packed {
        req_t        req;
        op_t         op;
        logic [31:0] instr;
        logic [4:0]  idx;
        logic [63:0] value;
    } dec_t;

    typedef struct packed {
        logic        wrote;
        logic [4:0]  dest_reg;
        logic [63:0] result_value;
        logic [3:0]  nzcv;
        logic        unsupported;
    } res_t;

    function automatic logic [63:0] shift_op(input logic [63:0] v, input logic [1:0] ty,
                                             input logic [5:0] amt_in, input logic sf);
        logic [5:0]   amt;
        logic [127:0] dbl;
        logic [63:0]  r;
        begin
            amt = sf ? amt_in : {1'b0, amt_in[4:0]};
            r = v;
            if (sf) begin
                case (ty)
                    2'd0: r = v << amt;
                    2'd1: r = v >> amt;
                    2'd2: r = 64'($signed(v) >>> amt);
                    default:
                    begin
                        dbl = {v, v} >> amt;
                        r = dbl[63:0];
                    end
                endcase
            end else begin
                case (ty)
                    2'd0: r = {32'd0, v[31:0] << amt[4:0]};
                    2'd1: r = {32'd0, v[31:0] >> amt[4:0]};
                    2'd2: r = {32'd0, 32'($signed(v[31:0]) >>> amt[4:0])};
                    default:
                    begin
                        dbl = {64'd0, v[31:0], v[31:0]} >> amt[4:0];
                        r = {32'd0, dbl[31:0]};
                    end
                endcase
            end
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ----- sv/a64dp_front.sv -----
// Front part: accepts items, classifies encodings, queues them for the back part.
`default_nettype none
module a64dp_front
    import a64dp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  req_type,
    input  wire logic [31:0] instr,
    input  wire logic [4:0]  reg_index,
    input  wire logic [63:0] reg_value,
    output logic             q_valid,
    input  wire logic        q_ready,
    output dec_t             q_item
);

    dec_t       mem_reg [QDEPTH];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    dec_t       d;
    logic       sf;
    logic [1:0] opc;

    always_comb
    begin
        sf  = instr[31];
        opc = instr[30:29];
        d.req   = req_t'(req_type);
        d.instr = instr;
        d.idx   = reg_index;
        d.value = reg_value;
        d.op    = OP_NOP;
        if (req_type == REQ_EXEC) begin
            if (instr[28:23] == 6'h22)
                d.op = OP_ADDI;
            else if (instr[28:23] == 6'h25)
                d.op = (opc == 2'd1 || (!sf && instr[22])) ? OP_UNSUP : OP_MOVW;
            else if (instr[28:24] == 5'h0A)
                d.op = (!sf && instr[15]) ? OP_UNSUP : OP_LOGIC;
            else if (instr[28:24] == 5'h0B)
                d.op = (instr[21] || instr[23:22] == 2'd3 || (!sf && instr[15]))
                       ? OP_UNSUP : OP_ADDR;
            else if (instr[28:24] == 5'h1B && opc == 2'd0 && instr[23:21] == 3'd0)
                d.op = OP_MADD;
            else
                d.op = OP_UNSUP;
        end
    end

    assign in_ready = (cnt_reg != 2'(QDEPTH));
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            mem_reg[wp_reg] <= d;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (in_valid && in_ready)
                wp_reg <= ~wp_reg;
            if (q_valid && q_ready)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
        end
    end

endmodule
`default_nettype wire

// ----- sv/a64dp_back.sv -----
// Back part: register file, flags and one item executed per cycle unless stalled.
`default_nettype none
module a64dp_back
    import a64dp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_valid,
    output logic      q_ready,
    input  dec_t      q_item,
    output logic      out_valid,
    input  wire logic out_ready,
    output res_t      out_res
);

    logic [63:0] rf_reg [NREGS];
    logic [3:0]  flags_reg, flags_next;
    logic        ov_reg;
    res_t        res_reg, res_next;
    logic        mstep_reg;
    logic [63:0] pll_reg, pll_next;
    logic [31:0] pcr_reg, pcr_next;
    logic        we;
    logic [4:0]  wa;
    logic [63:0] wd;
    logic [63:0] mask, a, bm, ra, b, bb, sum, rdv, prod, r, imm;
    logic [64:0] s65;
    logic [32:0] s33;
    logic        sf, cin, setf, ok, n, c, v;
    logic [4:0]  rd;
    logic [5:0]  pos;

    function automatic logic [63:0] rd_rf(input logic [4:0] i, input logic [63:0] f [NREGS]);
        return (i == ZR) ? 64'd0 : f[i];
    endfunction

    // multiply-add is taken only once its partial products are registered
    assign q_ready = (!ov_reg || out_ready) && (q_item.op != OP_MADD || mstep_reg);

    always_comb
    begin
        sf   = q_item.instr[31];
        mask = sf ? '1 : 64'h0000_0000_FFFF_FFFF;
        rd   = q_item.instr[4:0];
        a    = rd_rf(q_item.instr[9:5], rf_reg) & mask;
        bm   = rd_rf(q_item.instr[20:16], rf_reg) & mask;
        ra   = rd_rf(q_item.instr[14:10], rf_reg) & mask;
        rdv  = rd_rf(rd, rf_reg);
        flags_next = flags_reg;
        ok   = 1'b1;
        r    = 64'd0;
        b    = 64'd0;
        imm  = 64'd0;
        pos  = {q_item.instr[22:21], 4'd0};
        setf = q_item.instr[29];
        cin  = q_item.instr[30];
        // low half of the product from 32x32 pieces
        pll_next = {32'd0, a[31:0]} * {32'd0, bm[31:0]};
        pcr_next = a[31:0] * bm[63:32] + a[63:32] * bm[31:0];
        prod = pll_reg + {pcr_reg, 32'd0};
        if (q_item.op == OP_ADDI)
            b = q_item.instr[22] ? {40'd0, q_item.instr[21:10], 12'd0}
                                 : {52'd0, q_item.instr[21:10]};
        else
            b = shift_op(bm, q_item.instr[23:22], q_item.instr[15:10], sf);
        bb  = (cin ? ~b : b) & mask;
        s65 = {1'b0, a} + {1'b0, bb} + 65'(cin);
        s33 = {1'b0, a[31:0]} + {1'b0, bb[31:0]} + 33'(cin);
        sum = s65[63:0] & mask;
        n   = sf ? sum[63] : sum[31];
        c   = sf ? s65[64] : s33[32];
        v   = sf ? ((a[63] ^ sum[63]) & (bb[63] ^ sum[63]))
                 : ((a[31] ^ sum[31]) & (bb[31] ^ sum[31]));
        case (q_item.op)
            OP_ADDI, OP_ADDR:
            begin
                r = sum;
                if (setf)
                    flags_next = {n, sum == 64'd0, c, v};
            end
            OP_MOVW:
            begin
                imm = {48'd0, q_item.instr[20:5]} << pos;
                if (q_item.instr[30:29] == 2'd0)
                    r = ~imm;
                else if (q_item.instr[30:29] == 2'd2)
                    r = imm;
                else
                    r = (rdv & ~(64'hFFFF << pos)) | imm;
                r = r & mask;
            end
            OP_LOGIC:
            begin
                bb = (q_item.instr[21] ? ~b : b) & mask;
                case (q_item.instr[30:29])
                    2'd1:    r = a | bb;
                    2'd2:    r = a ^ bb;
                    default: r = a & bb;
                endcase
                if (q_item.instr[30:29] == 2'd3)
                    flags_next = {sf ? r[63] : r[31], r == 64'd0, 2'b00};
            end
            OP_MADD:
                r = (q_item.instr[15] ? ra - prod : ra + prod) & mask;
            default: ok = 1'b0;
        endcase

        res_next = '0;
        we = 1'b0;
        wa = q_item.idx;
        wd = q_item.value;
        case (q_item.req)
            REQ_EXEC:
            begin
                if (ok && q_item.op != OP_UNSUP) begin
                    res_next.wrote        = (rd != ZR);
                    res_next.dest_reg     = rd;
                    res_next.result_value = r;
                    we = 1'b1;
                    wa = rd;
                    wd = r;
                end else begin
                    res_next.unsupported = 1'b1;
                end
            end
            REQ_LOAD:
            begin
                res_next.wrote        = (q_item.idx != ZR);
                res_next.dest_reg     = q_item.idx;
                res_next.result_value = q_item.value;
                we = 1'b1;
            end
            REQ_READ:
            begin
                res_next.dest_reg     = q_item.idx;
                res_next.result_value = rd_rf(q_item.idx, rf_reg);
            end
            default: ;
        endcase
        if (q_item.req != REQ_EXEC || q_item.op == OP_UNSUP)
            flags_next = flags_reg;
        res_next.nzcv = flags_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < NREGS; i++)
                rf_reg[i] <= '0;
            flags_reg <= 4'd0;
            ov_reg    <= 1'b0;
            mstep_reg <= 1'b0;
        end else begin
            if (q_valid && q_ready) begin
                if (we && wa != ZR)
                    rf_reg[wa] <= wd;
                flags_reg <= flags_next;
                ov_reg    <= 1'b1;
            end else if (out_ready) begin
                ov_reg <= 1'b0;
            end
            if (q_valid && q_ready)
                mstep_reg <= 1'b0;
            else if (q_valid && q_item.op == OP_MADD)
                mstep_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_valid && q_ready)
            res_reg <= res_next;
        // hold the partial products once the second step has begun
        if (!mstep_reg) begin
            pll_reg <= pll_next;
            pcr_reg <= pcr_next;
        end
    end

    assign out_valid = ov_reg;
    assign out_res   = res_reg;

endmodule
`default_nettype wire

// ----- sv/a64_data_processing_execute_top.sv -----
// A64 data-processing execute block.
// Input stream s_axis: one item per request (execute, load or read register).
// Output stream m_axis: exactly one result item per input item, in order.
// An item enters a two-entry queue in the front part, where it is classified;
// the back part reads the register file and flags, executes and registers the
// result. Throughput is one item per cycle while the receiver accepts and no
// multiply-add is waiting; the register file and flags are updated at the edge
// that loads the output register, so the next item sees them directly.
// Multiply-add and multiply-subtract take two steps in the back part: the
// first forms and registers 32x32 partial products, the second adds them.
// Reset clears all 31 registers, the flags and the queue at once.
// When the receiver stalls, the result holds in the output register, the
// queue fills and s_axis_tready drops once both entries are taken.
`default_nettype none
module a64_data_processing_execute_top
    import a64dp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: [31:0] instr, [36:32] reg_index, [100:37] reg_value, zero pad
    input  wire logic [103:0] s_axis_tdata,
    // tuser: [1:0] req_type
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata: [0] wrote, [5:1] dest_reg, [69:6] result_value, [73:70] nzcv,
    //        [74] unsupported, zero pad
    output logic [79:0]       m_axis_tdata
);

    logic q_valid, q_ready;
    dec_t q_item;
    res_t res;

    a64dp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .req_type  (s_axis_tuser),
        .instr     (s_axis_tdata[31:0]),
        .reg_index (s_axis_tdata[36:32]),
        .reg_value (s_axis_tdata[100:37]),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item)
    );

    a64dp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    assign m_axis_tdata = {5'd0, res.unsupported, res.nzcv, res.result_value,
                           res.dest_reg, res.wrote};

endmodule
`default_nettype wire

// ----- sv/a64dp_checker.sv -----
// Port-level checks for the execute block, bound to the top level.
`default_nettype none
module a64dp_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [79:0] m_axis_tdata
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");

    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |-> ##[1:3] m_axis_tvalid)
        else $error("result missing after accept");

    a_unsup: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[74] |-> !m_axis_tdata[0] && m_axis_tdata[69:6] == 64'd0)
        else $error("unsupported item wrote a value");

    a_zr: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[5:1] == 5'd31 |-> !m_axis_tdata[0])
        else $error("zero register written");

endmodule

bind a64_data_processing_execute_top a64dp_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
